FILE: design/ffpa_pkg.sv
package ffpa_pkg;

    localparam int NumCells   = 32;
    localparam int IdxW       = $clog2(NumCells);
    localparam int CntW       = $clog2(NumCells + 1);
    localparam int MaxSharers = 63;
    localparam int ShrW       = 6;
    localparam int OffW       = 31;
    localparam int KbW        = 22;

    localparam logic [KbW-1:0] KbClamped = KbW'(1887436);

    // op codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_ATTACH = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_LOCK   = 2'd3;

    // result status codes
    localparam logic [3:0] ST_PLACED    = 4'd0;
    localparam logic [3:0] ST_COMPACTED = 4'd1;
    localparam logic [3:0] ST_EMPTY     = 4'd2;
    localparam logic [3:0] ST_NO_ROOM   = 4'd3;
    localparam logic [3:0] ST_ATTACHED  = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_DROPPED   = 4'd6;
    localparam logic [3:0] ST_FREED     = 4'd7;
    localparam logic [3:0] ST_LOCKED    = 4'd8;
    localparam logic [3:0] ST_FULL      = 4'd9;

    // cell commands
    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_LEFT  = 2'd1;
    localparam logic [1:0] CMD_RIGHT = 2'd2;
    localparam logic [1:0] CMD_LOAD  = 2'd3;

    typedef struct packed {
        logic [OffW-1:0] start;
        logic [OffW-1:0] len;
        logic [ShrW-1:0] shr;
        logic            lck;
    } t_chunk;

    typedef struct packed {
        logic [1:0] cmd;
        t_chunk     wdata;
    } t_cell_ctl;

endpackage

FILE: design/ffpa_cell.sv
module ffpa_cell (
    input  logic               i_clk,
    input  ffpa_pkg::t_cell_ctl i_ctl,
    input  ffpa_pkg::t_chunk    i_left,
    input  ffpa_pkg::t_chunk    i_right,
    output ffpa_pkg::t_chunk    o_q
);
    import ffpa_pkg::*;

    t_chunk r_q;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LEFT:  r_q <= i_left;
            CMD_RIGHT: r_q <= i_right;
            CMD_LOAD:  r_q <= i_ctl.wdata;
            default:   r_q <= r_q;
        endcase
    end

    assign o_q = r_q;

endmodule

FILE: design/first_fit_pool_allocator_compacting.sv
// First-fit pool allocator with compaction. The chunk table is a row of 32 cells
// in address order; inserts and frees shift the whole tail of the row by one
// cell at once, while searches walk it one cell per cycle, the compaction walk
// stalling while a move command waits on the output. Attach, release and lock
// walk the row up to the named chunk, then update it. Allocate answers trivial
// cases directly, else runs a first-fit scan and, on a miss with enough free
// space, compacts the row. Each result sits in one output register; a new item
// is taken only once the previous one is done. Writing pool_size_kb resets the
// table and is taken while idle.
module first_fit_pool_allocator_compacting (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode, request_bytes, chunk_offset, is_owner, lock_flag, zero pad
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, offset, move_source, move_length, free_bytes
    output logic [127:0] m_axis_tdata,
    // kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [21:0]  i_cfg_data
);
    import ffpa_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DEC     = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_INSERT  = 3'd4;
    localparam logic [2:0] S_FIND    = 3'd5;
    localparam logic [2:0] S_OPER    = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [CntW-1:0] r_k, n_k;
    logic [31:0]     r_prev, n_prev;
    logic [IdxW-1:0] r_fnd, n_fnd;
    logic [OffW-1:0] r_addr, n_addr;
    logic            r_cst, n_cst;
    logic [1:0]      r_op, n_op;
    logic [OffW-1:0] r_req, n_req;
    logic [OffW-1:0] r_coff, n_coff;
    logic            r_own, n_own;
    logic            r_lk, n_lk;
    logic            r_act, n_act;
    logic [CntW-1:0] r_used, n_used;
    logic [OffW-1:0] r_pool, n_pool;

    logic            r_ov, n_ov;
    logic            r_kind;
    logic [3:0]      r_stat;
    logic [OffW-1:0] r_off, r_src, r_len, r_free;
    logic            r_last;

    logic            e;
    logic            e_kind, e_last;
    logic [3:0]      e_stat;
    logic [OffW-1:0] e_off, e_src, e_len;

    t_chunk    cq [NumCells];
    t_cell_ctl ctl [NumCells];
    t_chunk    rd, wnew;
    logic [31:0] gap, rd_end;
    logic        can_emit, s_acc, c_acc;
    logic [KbW-1:0] kbc;
    t_chunk    zero_chunk;

    assign zero_chunk = '0;

    genvar g;
    generate
        for (g = 0; g < NumCells; g++) begin : g_cell
            t_chunk lft, rgt;
            if (g == 0) begin : g_l0
                assign lft = zero_chunk;
            end else begin : g_ln
                assign lft = cq[g-1];
            end
            if (g == NumCells - 1) begin : g_rl
                assign rgt = zero_chunk;
            end else begin : g_rn
                assign rgt = cq[g+1];
            end
            ffpa_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ctl[g]),
                .i_left (lft),
                .i_right(rgt),
                .o_q    (cq[g])
            );
        end
    endgenerate

    assign rd       = cq[r_k[IdxW-1:0]];
    assign gap      = {1'b0, rd.start} - r_prev;
    assign rd_end   = {1'b0, rd.start} + {1'b0, rd.len};
    assign can_emit = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign c_acc = i_cfg_valid && o_cfg_ready;
    assign kbc   = i_cfg_data[KbW-1] ? KbClamped : i_cfg_data;

    always_comb begin
        n_state = r_state; n_k = r_k; n_prev = r_prev; n_fnd = r_fnd;
        n_addr = r_addr; n_cst = r_cst; n_op = r_op; n_req = r_req;
        n_coff = r_coff; n_own = r_own; n_lk = r_lk; n_act = r_act;
        n_used = r_used; n_pool = r_pool;
        n_ov = r_ov && !m_axis_tready;
        e = 1'b0; e_kind = 1'b0; e_last = 1'b1; e_stat = ST_PLACED;
        e_off = '0; e_src = '0; e_len = '0;
        wnew = rd;
        for (int j = 0; j < NumCells; j++) begin
            ctl[j].cmd   = CMD_HOLD;
            ctl[j].wdata = rd;
        end

        case (r_state)
            S_IDLE: begin
                if (c_acc) begin
                    n_act  = (i_cfg_data != '0);
                    n_pool = {kbc[20:0], 10'd0};
                    n_used = (i_cfg_data != '0) ? CntW'(1) : '0;
                    ctl[0].cmd   = CMD_LOAD;
                    ctl[0].wdata = '{start: {kbc[20:0], 10'd0}, len: '0, shr: '0, lck: 1'b0};
                end
                if (s_acc) begin
                    n_op   = s_axis_tdata[1:0];
                    n_req  = s_axis_tdata[32:2];
                    n_coff = s_axis_tdata[63:33];
                    n_own  = s_axis_tdata[64];
                    n_lk   = s_axis_tdata[65];
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (can_emit) begin
                    n_k = '0; n_prev = '0;
                    if (r_op == OP_ALLOC) begin
                        if (r_req == '0) begin
                            e = 1'b1; e_stat = ST_EMPTY; n_state = S_IDLE;
                        end else if (!r_act) begin
                            e = 1'b1; e_stat = ST_NO_ROOM; n_state = S_IDLE;
                        end else if (r_used >= CntW'(NumCells)) begin
                            e = 1'b1; e_stat = ST_FULL; n_state = S_IDLE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (!r_act) begin
                        e = 1'b1; e_stat = ST_NOT_FOUND; n_state = S_IDLE;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_SCAN: begin
                if (r_k == r_used) begin
                    if (r_pool >= r_req) begin
                        n_k = '0; n_prev = '0; n_state = S_COMPACT;
                    end else if (can_emit) begin
                        e = 1'b1; e_stat = ST_NO_ROOM; n_state = S_IDLE;
                    end
                end else if (gap >= {1'b0, r_req}) begin
                    n_fnd = r_k[IdxW-1:0]; n_addr = r_prev[OffW-1:0];
                    n_cst = 1'b0; n_state = S_INSERT;
                end else begin
                    n_prev = rd_end; n_k = r_k + 1'b1;
                end
            end
            S_COMPACT: begin
                if (r_k == r_used) begin
                    if (can_emit) begin
                        e = 1'b1; e_stat = ST_NO_ROOM; n_state = S_IDLE;
                    end
                end else if (gap >= {1'b0, r_req}) begin
                    n_fnd = r_k[IdxW-1:0]; n_addr = r_prev[OffW-1:0];
                    n_cst = 1'b1; n_state = S_INSERT;
                end else if (gap != '0 && rd.len != '0 && !rd.lck) begin
                    if (can_emit) begin
                        e = 1'b1; e_kind = 1'b1; e_last = 1'b0;
                        e_off = r_prev[OffW-1:0]; e_src = rd.start; e_len = rd.len;
                        wnew.start = r_prev[OffW-1:0];
                        ctl[r_k[IdxW-1:0]].cmd   = CMD_LOAD;
                        ctl[r_k[IdxW-1:0]].wdata = wnew;
                        n_prev = r_prev + {1'b0, rd.len};
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    n_prev = rd_end; n_k = r_k + 1'b1;
                end
            end
            S_INSERT: begin
                if (can_emit) begin
                    for (int j = 0; j < NumCells; j++) begin
                        if (IdxW'(j) > r_fnd) ctl[j].cmd = CMD_LEFT;
                    end
                    ctl[r_fnd].cmd   = CMD_LOAD;
                    ctl[r_fnd].wdata = '{start: r_addr, len: r_req, shr: ShrW'(1), lck: 1'b0};
                    n_used = r_used + 1'b1;
                    n_pool = (r_pool >= r_req) ? r_pool - r_req : '0;
                    e = 1'b1; e_stat = r_cst ? ST_COMPACTED : ST_PLACED; e_off = r_addr;
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (r_k == r_used) begin
                    if (can_emit) begin
                        e = 1'b1; e_stat = ST_NOT_FOUND; n_state = S_IDLE;
                    end
                end else if (rd.start == r_coff && rd.len != '0) begin
                    n_state = S_OPER;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_OPER: begin
                if (can_emit) begin
                    e = 1'b1; n_state = S_IDLE;
                    ctl[r_k[IdxW-1:0]].cmd = CMD_LOAD;
                    case (r_op)
                        OP_ATTACH: begin
                            if (rd.shr < ShrW'(MaxSharers)) wnew.shr = rd.shr + 1'b1;
                            e_stat = ST_ATTACHED;
                        end
                        OP_FREE: begin
                            if (rd.shr > ShrW'(1)) begin
                                wnew.shr = rd.shr - 1'b1;
                                e_stat = ST_DROPPED;
                            end else if (!r_own) begin
                                e_stat = ST_DROPPED;
                            end else begin
                                for (int j = 0; j < NumCells; j++) begin
                                    if (IdxW'(j) >= r_k[IdxW-1:0]) ctl[j].cmd = CMD_RIGHT;
                                end
                                n_pool = r_pool + rd.len;
                                n_used = r_used - 1'b1;
                                e_stat = ST_FREED;
                            end
                        end
                        default: begin
                            wnew.lck = r_lk;
                            e_stat = ST_LOCKED;
                        end
                    endcase
                    if (ctl[r_k[IdxW-1:0]].cmd == CMD_LOAD) ctl[r_k[IdxW-1:0]].wdata = wnew;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (e) n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= 1'b0;
            r_used  <= '0;
            r_pool  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_used  <= n_used;
            r_pool  <= n_pool;
            r_ov    <= n_ov;
        end
        r_k <= n_k; r_prev <= n_prev; r_fnd <= n_fnd; r_addr <= n_addr;
        r_cst <= n_cst; r_op <= n_op; r_req <= n_req; r_coff <= n_coff;
        r_own <= n_own; r_lk <= n_lk;
        if (e) begin
            r_kind <= e_kind; r_stat <= e_stat; r_off <= e_off;
            r_src <= e_src; r_len <= e_len; r_last <= e_last;
            r_free <= n_pool;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_free, r_len, r_src, r_off, r_stat};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

endmodule

FILE: design/ffpa_checker.sv
module ffpa_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tlast
);
    // a move command is never the final result
    a_move_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
        else $error("move command marked last");

    // every final answer is marked last
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("final answer not marked last");

    // move commands carry a zero status
    a_move_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3:0] == 4'd0)
        else $error("move command with nonzero status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind first_fit_pool_allocator_compacting ffpa_checker u_ffpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
